// File: sv/lg_pkg.sv
// ----------------------------------------------------------------------------
// lg_pkg: shared types and constants for the life grid
// Field widths, mode codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lg_pkg;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_WRITE   = 2'd0;
  localparam mode_t MODE_READ    = 2'd1;
  localparam mode_t MODE_ADVANCE = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ACTIVE_HEIGHT = 1'b0;
  localparam cfg_idx_t CFG_ACTIVE_WIDTH  = 1'b1;

  localparam logic [CFG_W-1:0] RESET_HEIGHT = 7'd64;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 7'd64;

endpackage

`default_nettype wire

// File: sv/lg_if.sv
// ----------------------------------------------------------------------------
// lg_if: valid/ready channels of the life grid
// Command channel (mode, row, col, alive_in) and result channel
// (cell_alive, generation_done).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lg_in_if;
  import lg_pkg::*;

  logic             valid;
  logic             ready;
  mode_t            mode;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             alive_in;

  modport source (output valid, mode, row, col, alive_in, input ready);
  modport sink   (input valid, mode, row, col, alive_in, output ready);
endinterface

interface lg_out_if;
  logic valid;
  logic ready;
  logic cell_alive;
  logic generation_done;

  modport source (output valid, cell_alive, generation_done, input ready);
  modport sink   (input valid, cell_alive, generation_done, output ready);
endinterface

`default_nettype wire

// File: sv/lg_grid_mem.sv
// ----------------------------------------------------------------------------
// lg_grid_mem: cell grid storage
// One row word per entry, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lg_grid_mem #(
  parameter int ROWS = lg_pkg::DEF_GRID_ROWS,
  parameter int COLS = lg_pkg::DEF_GRID_COLS,
  localparam int AW  = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [COLS-1:0] wdata,
  input  logic [AW-1:0]   raddr,
  output logic [COLS-1:0] rdata
);
  import lg_pkg::*;

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/lg_row_rule.sv
// ----------------------------------------------------------------------------
// lg_row_rule: B3/S23 next state of one row
// Counts the eight neighbors of every column from the row itself and the rows above and below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lg_row_rule #(
  parameter int COLS = lg_pkg::DEF_GRID_COLS
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] here,
  input  logic [COLS-1:0] below,
  input  logic [COLS-1:0] mask,
  output logic [COLS-1:0] fresh
);
  import lg_pkg::*;

  localparam logic [3:0] NB_SURVIVE = 4'd2;
  localparam logic [3:0] NB_BIRTH   = 4'd3;

  // pad one dead column on each side; p[c+1] is column c
  logic [COLS+1:0] a_p;
  logic [COLS+1:0] h_p;
  logic [COLS+1:0] b_p;

  assign a_p = {1'b0, above, 1'b0};
  assign h_p = {1'b0, here, 1'b0};
  assign b_p = {1'b0, below, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic [3:0] n;
    assign n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
             + 4'(h_p[c])                + 4'(h_p[c+2])
             + 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
    assign fresh[c] = mask[c] & ((n == NB_BIRTH) | (here[c] & (n == NB_SURVIVE)));
  end

endmodule

`default_nettype wire

// File: sv/life_cellular_automaton_grid.sv
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid: Game of Life (B3/S23) grid engine
// Usage:
//   in_ch carries one command word: write a cell, read a cell or advance
//   the grid one generation. Every word gives one word on out_ch with
//   cell_alive (read) and generation_done (advance). cfg_we/cfg_index/
//   cfg_data set active_height and active_width; write them while idle.
//   Rows live in a one-read one-write memory with registered read data.
//   Cell write/read: read the row, modify, write back in state CELL, then
//   hand the result word over in FIN; no new word is taken before that.
//   Advance: rows stream through the memory one per cycle, writing row r
//   while reading row r+2; after the last row the result word is handed
//   over in FIN, and no new word is taken before that.
//   Reset: synchronous, active low. A clearing pass then writes every row
//   dead, during which in_ch.ready stays low.
//   A stalled receiver holds the result register; the finished next word
//   waits until the register is free, and in_ch.ready stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_cellular_automaton_grid #(
  parameter int GRID_ROWS = lg_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = lg_pkg::DEF_GRID_COLS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lg_in_if.sink                    in_ch,
  lg_out_if.source                 out_ch,
  input  logic                     cfg_we,
  input  lg_pkg::cfg_idx_t         cfg_index,
  input  logic [lg_pkg::CFG_W-1:0] cfg_data
);
  import lg_pkg::*;

  localparam int AW = $clog2(GRID_ROWS);
  localparam int KW = $clog2(GRID_ROWS + 2);

  localparam logic [KW-1:0] K_ONE      = KW'(1);
  localparam logic [KW-1:0] K_TWO      = KW'(2);
  localparam logic [KW-1:0] K_LAST     = KW'(GRID_ROWS + 1);
  localparam logic [KW-1:0] K_CLR_LAST = KW'(GRID_ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [KW-1:0]      k_r;
  mode_t              mode_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic               alive_r;
  logic [CFG_W-1:0]   height_r;
  logic [CFG_W-1:0]   width_r;
  logic [GRID_COLS-1:0] old_r;
  logic [GRID_COLS-1:0] cur_r;
  logic               res_cell_r;
  logic               res_gen_r;
  logic               out_valid_r;
  logic               out_cell_r;
  logic               out_gen_r;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [GRID_COLS-1:0] mem_rdata;

  logic [GRID_COLS-1:0] col_mask;
  logic [GRID_COLS-1:0] col_sel;
  logic [GRID_COLS-1:0] arriving;
  logic [GRID_COLS-1:0] fresh;
  logic [KW-1:0]        arr_idx;
  logic [KW-1:0]        wr_idx;
  logic                 arr_ok;
  logic                 wr_ok;
  logic                 in_area;
  logic                 hit;
  logic                 in_row_ok;
  logic                 in_accept;
  logic                 out_free;

  lg_grid_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lg_row_rule #(
    .COLS (GRID_COLS)
  ) u_rule (
    .above (old_r),
    .here  (cur_r),
    .below (arriving),
    .mask  (col_mask),
    .fresh (fresh)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cell_alive      = out_cell_r;
  assign out_ch.generation_done = out_gen_r;

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      col_mask[c] = (CFG_W'(c) < width_r);
      col_sel[c]  = (col_r == COL_W'(c));
    end
  end

  assign in_area = (32'(row_r) < 32'(GRID_ROWS)) && (CFG_W'(row_r) < height_r)
                && (32'(col_r) < 32'(GRID_COLS)) && (CFG_W'(col_r) < width_r);
  assign hit     = |(mem_rdata & col_sel);

  assign in_row_ok = (32'(in_ch.row) < 32'(GRID_ROWS));

  // advance: data arriving now is row k-1; the row written now is k-2
  assign arr_idx  = k_r - K_ONE;
  assign wr_idx   = k_r - K_TWO;
  assign arr_ok   = (k_r != '0) && (32'(arr_idx) < 32'(GRID_ROWS))
                 && (32'(arr_idx) < 32'(height_r));
  assign wr_ok    = (32'(wr_idx) < 32'(height_r));
  assign arriving = arr_ok ? (mem_rdata & col_mask) : '0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = k_r[AW-1:0];
      end
      ST_IDLE: begin
        mem_raddr = in_row_ok ? AW'(in_ch.row) : '0;
      end
      ST_CELL: begin
        mem_we    = (mode_r == MODE_WRITE) && in_area;
        mem_waddr = AW'(row_r);
        mem_wdata = alive_r ? (mem_rdata | col_sel) : (mem_rdata & ~col_sel);
      end
      ST_ADV: begin
        mem_raddr = (32'(k_r) < 32'(GRID_ROWS)) ? k_r[AW-1:0] : '0;
        if (k_r >= K_TWO) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx[AW-1:0];
          // rows past the active height die outright
          mem_wdata = wr_ok ? fresh : '0;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      k_r         <= '0;
      height_r    <= RESET_HEIGHT;
      width_r     <= RESET_WIDTH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ACTIVE_HEIGHT: height_r <= cfg_data;
          CFG_ACTIVE_WIDTH:  width_r  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLR: begin
          k_r <= k_r + K_ONE;
          if (k_r == K_CLR_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            mode_r     <= in_ch.mode;
            row_r      <= in_ch.row;
            col_r      <= in_ch.col;
            alive_r    <= in_ch.alive_in;
            res_cell_r <= 1'b0;
            res_gen_r  <= 1'b0;
            case (in_ch.mode) inside
              MODE_WRITE, MODE_READ: begin
                state_r <= ST_CELL;
              end
              MODE_ADVANCE: begin
                state_r <= ST_ADV;
                k_r     <= '0;
                old_r   <= '0;
                cur_r   <= '0;
              end
              default: begin
                // unused mode: drop, answer with zeros
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_CELL: begin
          res_cell_r <= (mode_r == MODE_READ) && in_area && hit;
          state_r    <= ST_FIN;
        end
        ST_ADV: begin
          old_r <= cur_r;
          cur_r <= arriving;
          k_r   <= k_r + K_ONE;
          if (k_r == K_LAST) begin
            res_gen_r <= 1'b1;
            state_r   <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_cell_r  <= res_cell_r;
            out_gen_r   <= res_gen_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("word accepted while previous word still in flight");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_cell_r && out_gen_r))
    else $error("result flags both a read and a generation");

  a_adv_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADV && mem_we) |-> ((mem_wdata & ~col_mask) == '0))
    else $error("advance wrote live cells outside the active width");

  a_adv_height: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADV && mem_we && mem_wdata != '0)
      |-> (32'(mem_waddr) < 32'(height_r)))
    else $error("advance wrote live cells outside the active height");

  a_clear_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (mem_we && mem_wdata == '0 && !in_ch.ready))
    else $error("clearing pass misbehaved");
`endif

endmodule

`default_nettype wire
